>>> src/dae_pkg.sv
// Shared types and constants of the DNS answer IPv4 extractor.
package dae_pkg;

    // Fixed sizes in the DNS message layout.
    localparam int HDR_BYTES   = 12;
    localparam int FIXED_BYTES = 10;
    localparam int QTAIL_SKIP  = 5;
    localparam int ADDR_BYTES  = 4;
    localparam logic [7:0] PTR_MASK = 8'hC0;

    // Resource record codes that carry an IPv4 address.
    localparam logic [15:0] RR_TYPE_A   = 16'd1;
    localparam logic [15:0] RR_A_LENGTH = 16'd4;

    // Header bytes that hold the answer count, and the last header byte.
    localparam logic [11:0] IDX_ANCOUNT_HI = 12'd6;
    localparam logic [11:0] IDX_ANCOUNT_LO = 12'd7;
    localparam logic [11:0] IDX_HDR_LAST   = 12'd11;
    localparam logic [11:0] IDX_MAX        = 12'hFFF;

    // Event queue between parser and output stage.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Kind codes carried on the output tuser.
    localparam logic KIND_ADDR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_QNAME,
        PH_ANS_START,
        PH_ANAME,
        PH_FIXED,
        PH_ADDR,
        PH_DONE
    } t_phase;

    // Results caused by one input beat: an address, a summary, or both.
    typedef struct packed {
        logic        has_addr;
        logic        has_sum;
        logic [31:0] addr;
        logic [7:0]  count;
    } t_evt;

endpackage

>>> src/dae_front.sv
// Byte parser: walks the DNS response and raises address and summary events.
module dae_front #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_ready,
    input  logic [7:0]    i_data,
    input  logic [11:0]   i_len,
    input  logic          i_last,
    output logic          o_push,
    output dae_pkg::t_evt o_evt
);

    dae_pkg::t_phase r_phase, n_phase;
    logic [11:0] r_byte_index, n_byte_index;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_answers, n_answers;
    logic [15:0] r_rtype, n_rtype;
    logic [15:0] r_rlen, n_rlen;
    logic [3:0]  r_fo, n_fo;
    logic [31:0] r_shift, n_shift;
    logic [7:0]  r_found, n_found;

    logic        w_acc;
    logic [11:0] w_len;
    logic [12:0] w_i13;
    logic [12:0] w_len13;
    logic        w_parse;
    logic        w_skipping;
    logic        w_is_ptr;
    logic        w_ans_stop;
    logic        w_fix_stop;
    logic        w_fix_end;
    logic [15:0] w_rtype_nx;
    logic [15:0] w_rlen_nx;
    logic        w_is_a;
    logic        w_addr_end;
    logic        w_emit_addr;

    // Beat handshake and the length clamped to the largest packet.
    assign w_acc   = i_valid && i_ready;
    assign w_len   = (17'(i_len) > 17'(MAX_PACKET_BYTES)) ? 12'(MAX_PACKET_BYTES) : i_len;
    assign w_i13   = {1'b0, r_byte_index};
    assign w_len13 = {1'b0, w_len};
    assign w_parse = (w_len >= 12'(dae_pkg::HDR_BYTES)) && (r_byte_index < w_len);

    // Conditions shared by the phase logic and the datapath.
    assign w_skipping = (r_skip != 16'd0);
    assign w_is_ptr   = ((i_data & dae_pkg::PTR_MASK) == dae_pkg::PTR_MASK);
    assign w_ans_stop = (r_answers == 16'd0) ||
                        (w_i13 + 13'(dae_pkg::HDR_BYTES) > w_len13);
    assign w_fix_stop = (r_fo == 4'd0) && (w_i13 + 13'(dae_pkg::FIXED_BYTES) > w_len13);
    assign w_fix_end  = (r_fo >= 4'(dae_pkg::FIXED_BYTES - 1));
    assign w_rtype_nx = (r_fo == 4'd0) ? {i_data, 8'h00} :
                        (r_fo == 4'd1) ? {r_rtype[15:8], i_data} : r_rtype;
    assign w_rlen_nx  = (r_fo == 4'd8) ? {i_data, 8'h00} :
                        (r_fo == 4'd9) ? {r_rlen[15:8], i_data} : r_rlen;
    assign w_is_a     = (w_rtype_nx == dae_pkg::RR_TYPE_A) &&
                        (w_rlen_nx == dae_pkg::RR_A_LENGTH) &&
                        (w_i13 + 13'(1 + dae_pkg::ADDR_BYTES) <= w_len13);
    assign w_addr_end = (r_fo >= 4'(dae_pkg::ADDR_BYTES - 1));

    // Next parser phase.
    always_comb begin
        n_phase = r_phase;
        if (w_acc && i_last) begin
            n_phase = dae_pkg::PH_HEADER;
        end else if (w_acc && w_parse) begin
            unique case (r_phase)
                dae_pkg::PH_HEADER: begin
                    if (r_byte_index == dae_pkg::IDX_HDR_LAST) n_phase = dae_pkg::PH_QNAME;
                end
                dae_pkg::PH_QNAME: begin
                    if (!w_skipping && i_data == 8'd0) n_phase = dae_pkg::PH_ANS_START;
                end
                dae_pkg::PH_ANS_START: begin
                    if (!w_skipping) begin
                        if (w_ans_stop) n_phase = dae_pkg::PH_DONE;
                        else if (w_is_ptr || i_data == 8'd0) n_phase = dae_pkg::PH_FIXED;
                        else n_phase = dae_pkg::PH_ANAME;
                    end
                end
                dae_pkg::PH_ANAME: begin
                    if (!w_skipping && i_data == 8'd0) n_phase = dae_pkg::PH_FIXED;
                end
                dae_pkg::PH_FIXED: begin
                    if (!w_skipping) begin
                        if (w_fix_stop) n_phase = dae_pkg::PH_DONE;
                        else if (w_fix_end) begin
                            n_phase = w_is_a ? dae_pkg::PH_ADDR : dae_pkg::PH_ANS_START;
                        end
                    end
                end
                dae_pkg::PH_ADDR: begin
                    if (!w_skipping && w_addr_end) n_phase = dae_pkg::PH_ANS_START;
                end
                dae_pkg::PH_DONE: n_phase = dae_pkg::PH_DONE;
                default:          n_phase = dae_pkg::PH_DONE;
            endcase
        end
    end

    // Datapath updates and event outputs.
    always_comb begin
        n_byte_index = r_byte_index;
        n_skip       = r_skip;
        n_answers    = r_answers;
        n_rtype      = r_rtype;
        n_rlen       = r_rlen;
        n_fo         = r_fo;
        n_shift      = r_shift;
        n_found      = r_found;
        w_emit_addr  = 1'b0;
        if (w_acc && w_parse) begin
            case (r_phase)
                dae_pkg::PH_HEADER: begin
                    if (r_byte_index == dae_pkg::IDX_ANCOUNT_HI) n_answers = {i_data, 8'h00};
                    if (r_byte_index == dae_pkg::IDX_ANCOUNT_LO) begin
                        n_answers = {r_answers[15:8], i_data};
                    end
                    if (r_byte_index == dae_pkg::IDX_HDR_LAST) n_skip = 16'd0;
                end
                dae_pkg::PH_DONE: ;
                default: begin
                    if (w_skipping) begin
                        n_skip = r_skip - 16'd1;
                    end else begin
                        case (r_phase)
                            dae_pkg::PH_QNAME: begin
                                n_skip = (i_data != 8'd0) ? {8'h00, i_data} :
                                         16'(dae_pkg::QTAIL_SKIP - 1);
                            end
                            dae_pkg::PH_ANS_START: begin
                                if (!w_ans_stop) begin
                                    n_answers = r_answers - 16'd1;
                                    if (w_is_ptr) begin
                                        n_skip = 16'd1;
                                        n_fo   = 4'd0;
                                    end else if (i_data != 8'd0) begin
                                        n_skip = {8'h00, i_data};
                                    end else begin
                                        n_skip = 16'd0;
                                        n_fo   = 4'd0;
                                    end
                                end
                            end
                            dae_pkg::PH_ANAME: begin
                                if (i_data != 8'd0) begin
                                    n_skip = {8'h00, i_data};
                                end else begin
                                    n_skip = 16'd0;
                                    n_fo   = 4'd0;
                                end
                            end
                            dae_pkg::PH_FIXED: begin
                                if (!w_fix_stop) begin
                                    n_rtype = w_rtype_nx;
                                    n_rlen  = w_rlen_nx;
                                    if (w_fix_end) begin
                                        n_fo = 4'd0;
                                        if (w_is_a) n_shift = 32'd0;
                                        else        n_skip  = w_rlen_nx;
                                    end else begin
                                        n_fo = r_fo + 4'd1;
                                    end
                                end
                            end
                            dae_pkg::PH_ADDR: begin
                                n_shift = {r_shift[23:0], i_data};
                                if (w_addr_end) begin
                                    if (r_found != 8'hFF) n_found = r_found + 8'd1;
                                    w_emit_addr = 1'b1;
                                    n_fo        = 4'd0;
                                    n_skip      = 16'd0;
                                end else begin
                                    n_fo = r_fo + 4'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end

        // Both results of one beat carry the count after this beat.
        o_evt.has_addr = w_emit_addr;
        o_evt.has_sum  = w_acc && i_last;
        o_evt.addr     = n_shift;
        o_evt.count    = n_found;
        o_push         = w_emit_addr || (w_acc && i_last);

        // The last byte returns all per-packet state to its reset value.
        if (w_acc && i_last) begin
            n_byte_index = 12'd0;
            n_skip       = 16'd0;
            n_answers    = 16'd0;
            n_rtype      = 16'd0;
            n_rlen       = 16'd0;
            n_fo         = 4'd0;
            n_shift      = 32'd0;
            n_found      = 8'd0;
        end else if (w_acc) begin
            n_byte_index = (r_byte_index != dae_pkg::IDX_MAX) ? r_byte_index + 12'd1 :
                           dae_pkg::IDX_MAX;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dae_pkg::PH_HEADER;
            r_byte_index <= 12'd0;
            r_skip       <= 16'd0;
            r_answers    <= 16'd0;
            r_rtype      <= 16'd0;
            r_rlen       <= 16'd0;
            r_fo         <= 4'd0;
            r_shift      <= 32'd0;
            r_found      <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_skip       <= n_skip;
            r_answers    <= n_answers;
            r_rtype      <= n_rtype;
            r_rlen       <= n_rlen;
            r_fo         <= n_fo;
            r_shift      <= n_shift;
            r_found      <= n_found;
        end
    end

    // A last byte leaves the parser at the start of a fresh packet.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_last) |=> (r_byte_index == 12'd0 && r_found == 8'd0 &&
                               r_phase == dae_pkg::PH_HEADER))
        else $error("parser state not cleared after last byte");

    // Once parsing has stopped, only the last byte leaves the stopped phase.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dae_pkg::PH_DONE && !(w_acc && i_last)) |=> r_phase == dae_pkg::PH_DONE)
        else $error("parser left stopped phase before end of packet");

endmodule

>>> src/dae_queue.sv
// Short event queue that decouples the parser from the output stage.
module dae_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dae_pkg::t_evt i_evt,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output dae_pkg::t_evt o_evt
);

    dae_pkg::t_evt r_mem [dae_pkg::QDEPTH];
    logic [dae_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [dae_pkg::QCNT_W-1:0] r_count;
    logic w_pop;

    assign o_ready = (r_count != dae_pkg::QCNT_W'(dae_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_evt;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dae_pkg::QCNT_W'(dae_pkg::QDEPTH))
        else $error("queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != dae_pkg::QCNT_W'(dae_pkg::QDEPTH) || w_pop))
        else $error("event pushed into a full queue");

endmodule

>>> src/dae_back.sv
// Output stage: turns queued events into address and summary beats.
module dae_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dae_pkg::t_evt i_evt,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_addr,
    output logic [7:0]    o_count,
    output logic          o_kind,
    output logic          o_last
);

    logic        r_pend_addr, n_pend_addr;
    logic        r_pend_sum, n_pend_sum;
    logic [31:0] r_addr, n_addr;
    logic [7:0]  r_count, n_count;
    logic        w_fire;
    logic        w_final;

    // The address beat goes out before the summary of the same byte.
    assign o_valid = r_pend_addr || r_pend_sum;
    assign o_kind  = r_pend_addr ? dae_pkg::KIND_ADDR : dae_pkg::KIND_SUMMARY;
    assign o_addr  = r_pend_addr ? r_addr : 32'd0;
    assign o_count = r_count;
    assign o_last  = !r_pend_addr;

    assign w_fire  = o_valid && i_ready;
    assign w_final = w_fire && !(r_pend_addr && r_pend_sum);
    assign o_pop   = i_valid && (!o_valid || w_final);

    // Retire the sent beat, then load the next event when free.
    always_comb begin
        n_pend_addr = r_pend_addr;
        n_pend_sum  = r_pend_sum;
        n_addr      = r_addr;
        n_count     = r_count;
        if (w_fire) begin
            if (r_pend_addr) n_pend_addr = 1'b0;
            else             n_pend_sum  = 1'b0;
        end
        if (o_pop) begin
            n_pend_addr = i_evt.has_addr;
            n_pend_sum  = i_evt.has_sum;
            n_addr      = i_evt.addr;
            n_count     = i_evt.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_addr <= 1'b0;
            r_pend_sum  <= 1'b0;
        end else begin
            r_pend_addr <= n_pend_addr;
            r_pend_sum  <= n_pend_sum;
        end
        r_addr  <= n_addr;
        r_count <= n_count;
    end

    // Every queued event carries at least one result.
    a_evt_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_evt.has_addr || i_evt.has_sum))
        else $error("empty event taken from queue");

endmodule

>>> src/dns_answer_ipv4_extractor.sv
// Top level of the DNS answer IPv4 extractor.
//
//   Channel   Dir  tdata (low bit up)                      tuser        tlast
//   s_axis    in   data_byte[7:0], packet_length[19:8]      -            last_byte
//   m_axis    out  ipv4_address[31:0], address_count[39:32] result_kind  last_of_packet
//
// One packet byte is taken per clock while the event queue has room; the parser updates
// its counters in the cycle a beat is accepted, so input then runs at one beat per cycle.
// A byte yields at most two output beats; the output stage sends one beat per cycle
// while m_axis_tready is high, from a four-entry event queue, so a byte with both results
// takes two beats. Results are registered in the event queue and then in the output stage.
// s_axis_tready drops only while the event queue is full. Reset is synchronous,
// active low, and returns the parser to the start of a packet.
module dns_answer_ipv4_extractor #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte, packet_length
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // ipv4_address, address_count
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast
);

    logic          w_push;
    dae_pkg::t_evt w_push_evt;
    logic          w_q_valid;
    dae_pkg::t_evt w_q_evt;
    logic          w_pop;
    logic [31:0]   w_addr;
    logic [7:0]    w_count;

    dae_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_ready (s_axis_tready),
        .i_data  (s_axis_tdata[7:0]),
        .i_len   (s_axis_tdata[19:8]),
        .i_last  (s_axis_tlast),
        .o_push  (w_push),
        .o_evt   (w_push_evt)
    );

    dae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_push_evt),
        .o_ready (s_axis_tready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_evt   (w_q_evt)
    );

    dae_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_evt   (w_q_evt),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_addr  (w_addr),
        .o_count (w_count),
        .o_kind  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {w_count, w_addr};

endmodule

>>> test/dae_checker.sv
// Checker for the DNS answer IPv4 extractor: predicts result beats and compares them.
module dae_checker #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // data_byte, packet_length
    input  logic        i_s_tlast,   // last_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // ipv4_address, address_count
    input  logic        i_m_tuser,   // result_kind
    input  logic        i_m_tlast,   // last_of_packet
    output int          o_error_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Byte offsets inside the fixed part of an answer record.
    localparam int OFF_TYPE_HI  = 0;
    localparam int OFF_TYPE_LO  = 1;
    localparam int OFF_RDLEN_HI = 8;
    localparam int OFF_RDLEN_LO = 9;

    typedef struct {
        logic        kind;
        logic [31:0] addr;
        logic [7:0]  count;
        logic        eop;
    } t_result;

    // Parser state of the prediction.
    logic [11:0]     byte_idx;
    dae_pkg::t_phase phase;
    logic [16:0]     skip_left;
    logic [15:0]     answers_left;
    logic [15:0]     rr_type;
    logic [15:0]     rr_len;
    logic [3:0]      fld_off;
    logic [31:0]     addr_acc;
    logic [7:0]      found;

    t_result     expected_q[$];
    int          errors = 0;

    // Append one expectation behind the ones already waiting.
    function automatic void add_expected(t_result r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    // Return every per-packet register to its start-of-packet value.
    function automatic void clear_packet_state();
        byte_idx     = '0;
        phase        = dae_pkg::PH_HEADER;
        skip_left    = '0;
        answers_left = '0;
        rr_type      = '0;
        rr_len       = '0;
        fld_off      = '0;
        addr_acc     = '0;
        found        = '0;
    endfunction

    // Advance the parser by one byte that lies inside the packet.
    function automatic void parse_dns_byte(logic [7:0] b, int idx, int len);
        t_result res;
        if (phase == dae_pkg::PH_HEADER) begin
            if (idx == dae_pkg::IDX_ANCOUNT_HI) answers_left = {b, 8'h00};
            if (idx == dae_pkg::IDX_ANCOUNT_LO) answers_left[7:0] = b;
            if (idx == dae_pkg::IDX_HDR_LAST) begin
                phase     = dae_pkg::PH_QNAME;
                skip_left = '0;
            end
            return;
        end
        if (phase == dae_pkg::PH_DONE) return;
        if (skip_left != 0) begin
            skip_left--;
            return;
        end
        case (phase)
            dae_pkg::PH_QNAME: begin
                if (b != 0) begin
                    skip_left = 17'(b);
                end else begin
                    skip_left = 17'(dae_pkg::QTAIL_SKIP - 1);
                    phase     = dae_pkg::PH_ANS_START;
                end
            end
            dae_pkg::PH_ANS_START: begin
                if (answers_left == 0 || idx + dae_pkg::HDR_BYTES > len) begin
                    phase = dae_pkg::PH_DONE;
                end else begin
                    answers_left--;
                    if ((b & dae_pkg::PTR_MASK) == dae_pkg::PTR_MASK) begin
                        // Compressed name: one more byte of pointer to skip.
                        skip_left = 17'd1;
                        phase     = dae_pkg::PH_FIXED;
                        fld_off   = '0;
                    end else if (b != 0) begin
                        skip_left = 17'(b);
                        phase     = dae_pkg::PH_ANAME;
                    end else begin
                        skip_left = '0;
                        phase     = dae_pkg::PH_FIXED;
                        fld_off   = '0;
                    end
                end
            end
            dae_pkg::PH_ANAME: begin
                if (b != 0) begin
                    skip_left = 17'(b);
                end else begin
                    skip_left = '0;
                    phase     = dae_pkg::PH_FIXED;
                    fld_off   = '0;
                end
            end
            dae_pkg::PH_FIXED: begin
                if (fld_off == 0 && idx + dae_pkg::FIXED_BYTES > len) begin
                    phase = dae_pkg::PH_DONE;
                end else begin
                    if (fld_off == OFF_TYPE_HI) rr_type = {b, 8'h00};
                    else if (fld_off == OFF_TYPE_LO) rr_type[7:0] = b;
                    else if (fld_off == OFF_RDLEN_HI) rr_len = {b, 8'h00};
                    else if (fld_off == OFF_RDLEN_LO) rr_len[7:0] = b;
                    if (fld_off >= dae_pkg::FIXED_BYTES - 1) begin
                        fld_off = '0;
                        if (rr_type == dae_pkg::RR_TYPE_A && rr_len == dae_pkg::RR_A_LENGTH &&
                            idx + 1 + dae_pkg::ADDR_BYTES <= len) begin
                            phase    = dae_pkg::PH_ADDR;
                            addr_acc = '0;
                        end else begin
                            skip_left = 17'(rr_len);
                            phase     = dae_pkg::PH_ANS_START;
                        end
                    end else begin
                        fld_off++;
                    end
                end
            end
            dae_pkg::PH_ADDR: begin
                addr_acc = {addr_acc[23:0], b};
                if (fld_off >= dae_pkg::ADDR_BYTES - 1) begin
                    if (found != 8'hFF) found++;
                    res.kind  = dae_pkg::KIND_ADDR;
                    res.addr  = addr_acc;
                    res.count = found;
                    res.eop   = 1'b0;
                    add_expected(res);
                    fld_off   = '0;
                    skip_left = '0;
                    phase     = dae_pkg::PH_ANS_START;
                end else begin
                    fld_off++;
                end
            end
            default: phase = dae_pkg::PH_DONE;
        endcase
    endfunction

    // Work out the results of one accepted input beat.
    function automatic void predict_beat(logic [23:0] data, logic last);
        t_result res;
        logic [7:0] b;
        int plen;
        int len;
        int idx;
        b    = data[7:0];
        plen = int'(data[19:8]);
        len  = (plen > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : plen;
        idx  = int'(byte_idx);
        if (len >= dae_pkg::HDR_BYTES && idx < len) parse_dns_byte(b, idx, len);
        if (last) begin
            res.kind  = dae_pkg::KIND_SUMMARY;
            res.addr  = '0;
            res.count = found;
            res.eop   = 1'b1;
            add_expected(res);
            clear_packet_state();
        end else if (byte_idx != dae_pkg::IDX_MAX) begin
            byte_idx++;
        end
    endfunction

    function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
        end
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function automatic void check_result();
        t_result want;
        if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: kind %0d address 0x%0h count %0d",
                   i_m_tuser, i_m_tdata[31:0], i_m_tdata[39:32]);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        flag_field("result_kind", 32'(want.kind), 32'(i_m_tuser));
        flag_field("ipv4_address", want.addr, i_m_tdata[31:0]);
        flag_field("address_count", 32'(want.count), 32'(i_m_tdata[39:32]));
        flag_field("last_of_packet", 32'(want.eop), 32'(i_m_tlast));
    endfunction

    // Results are checked before new expectations are queued at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_packet_state();
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_s_tvalid && i_s_tready) predict_beat(i_s_tdata, i_s_tlast);
        end
        o_pending     <= expected_q.size();
        o_error_count <= errors;
    end

endmodule

>>> test/tb.sv
// Testbench top for the DNS answer IPv4 extractor: clock, reset, packet stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BYTES  = 20;
    localparam int NAME_POINTER = -1;
    localparam int NAME_ROOT    = 0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // data_byte, packet_length
    logic        s_axis_tlast = 1'b0; // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // ipv4_address, address_count
    logic        m_axis_tuser;        // result_kind
    logic        m_axis_tlast;        // last_of_packet

    int          error_count;
    int          pending;
    int          cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          sent_count = 0;
    int          idle_by_phase[4] = '{0, 50, 0, 8};
    int          stall_by_phase[4] = '{0, 0, 50, 8};
    logic [7:0]  pkt[$];

    dns_answer_ipv4_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dae_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tlast     (m_axis_tlast),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver side: random stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Append one byte to the packet under construction.
    function automatic void add_byte(logic [7:0] v);
        pkt.insert(pkt.size(), v);
    endfunction

    function automatic void push_rand(int n);
        repeat (n) add_byte(8'($urandom()));
    endfunction

    // Header with the given answer count; all other header bytes random.
    function automatic void start_response(logic [15:0] ancount);
        pkt.delete();
        push_rand(6);
        add_byte(ancount[15:8]);
        add_byte(ancount[7:0]);
        push_rand(4);
    endfunction

    // Name as a pointer, the root, or a run of short labels.
    function automatic void push_name(int labels);
        int n;
        if (labels == NAME_POINTER) begin
            add_byte({2'b11, 6'($urandom())});
            push_rand(1);
        end else begin
            repeat (labels) begin
                n = $urandom_range(1, 4);
                add_byte(8'(n));
                push_rand(n);
            end
            add_byte(8'h00);
        end
    endfunction

    function automatic void push_question(int labels);
        push_name(labels);
        push_rand(4);
    endfunction

    // Answer name and the fixed part: type, class, TTL and data length.
    function automatic void push_record_head(int labels, logic [15:0] rtype, logic [15:0] rdlen);
        push_name(labels);
        add_byte(rtype[15:8]);
        add_byte(rtype[7:0]);
        push_rand(6);
        add_byte(rdlen[15:8]);
        add_byte(rdlen[7:0]);
    endfunction

    function automatic void push_a_record(int labels, logic [31:0] addr);
        push_record_head(labels, dae_pkg::RR_TYPE_A, dae_pkg::RR_A_LENGTH);
        for (int k = 3; k >= 0; k--) add_byte(addr[8*k +: 8]);
    endfunction

    function automatic void push_other_record(int labels, logic [15:0] rtype, int rdlen);
        push_record_head(labels, rtype, 16'(rdlen));
        push_rand(rdlen);
    endfunction

    // One input beat, after a random idle gap; valid stays high after it.
    task automatic send_beat(logic [7:0] b, logic [11:0] plen, logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, plen, b};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    task automatic send_packet(logic [11:0] plen);
        foreach (pkt[k]) send_beat(pkt[k], plen, k == pkt.size() - 1);
    endtask

    // Hold the sender until every expected result has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly well-formed responses, some broken ones and some noise.
    task automatic send_random_packet();
        int kind;
        int answers;
        int labels;
        int cut;
        logic [11:0] plen;
        kind    = $urandom_range(0, 99);
        answers = $urandom_range(0, 4);
        start_response(16'(answers));
        push_question($urandom_range(1, 3));
        repeat (answers) begin
            labels = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : NAME_POINTER;
            if ($urandom_range(0, 3) != 0)
                push_a_record(labels, $urandom());
            else
                push_other_record(labels,
                                  ($urandom_range(0, 2) == 0) ? dae_pkg::RR_TYPE_A :
                                                                16'($urandom()),
                                  $urandom_range(0, 6));
        end
        plen = 12'(pkt.size());
        if (kind >= 72 && kind < 92) begin
            case ($urandom_range(0, 3))
                0: pkt[$urandom_range(12, pkt.size() - 1)] = 8'($urandom());
                1: begin
                    cut = $urandom_range(1, pkt.size() - 1);
                    repeat (cut) void'(pkt.pop_back());
                end
                2: plen = 12'($urandom());
                default: begin
                    pkt[6] = 8'($urandom_range(0, 1) ? $urandom() : 0);
                    pkt[7] = 8'($urandom());
                end
            endcase
        end else if (kind >= 92) begin
            pkt.delete();
            push_rand($urandom_range(1, 24));
            plen = 12'($urandom());
        end
        send_packet(plen);
    endtask

    initial begin
        int start;
        int size_ok;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short packets: only a summary with a zero count.
        pkt.delete();
        push_rand(11);
        send_packet(12'd11);
        pkt.delete();
        add_byte(8'hFF);
        send_packet(12'd0);
        start_response(16'hFFFF);
        send_packet(12'd12);

        // Every record shape; the final address ends on the last byte.
        start_response(16'd6);
        push_question(2);
        push_a_record(NAME_POINTER, 32'hFFFF_FFFF);
        push_other_record(3, 16'h0005, 3);
        push_a_record(NAME_ROOT, 32'h0000_0000);
        push_other_record(NAME_POINTER, dae_pkg::RR_TYPE_A, 5);
        push_other_record(1, 16'h0100, 4);
        push_a_record(2, $urandom());
        send_packet(12'(pkt.size()));

        // Lengths above the maximum are clamped.
        start_response(16'd2);
        push_question(1);
        push_a_record(NAME_POINTER, 32'h5A5A_A5A5);
        push_a_record(1, $urandom());
        send_packet(12'hFFF);
        send_packet(12'h800);

        // Last byte arrives in the middle of an address.
        start_response(16'd2);
        push_question(1);
        push_a_record(NAME_POINTER, $urandom());
        push_a_record(NAME_POINTER, $urandom());
        size_ok = pkt.size();
        void'(pkt.pop_back());
        void'(pkt.pop_back());
        send_packet(12'(size_ok));

        // A full record beyond the declared length is ignored.
        start_response(16'd2);
        push_question(1);
        push_a_record(NAME_POINTER, $urandom());
        size_ok = pkt.size();
        push_a_record(NAME_POINTER, $urandom());
        send_packet(12'(size_ok));

        // Address that does not fit inside the declared length.
        start_response(16'd1);
        push_question(1);
        push_a_record(NAME_POINTER, $urandom());
        send_packet(12'(pkt.size() - 1));

        // Label length that points past the end of the packet.
        start_response(16'd1);
        add_byte(8'hFF);
        push_rand(10);
        send_packet(12'(pkt.size()));

        // Pointer-like byte inside a label run is a label length.
        start_response(16'd1);
        add_byte(8'h01);
        push_rand(1);
        add_byte(8'hC3);
        push_rand(8'hC3);
        add_byte(8'h00);
        push_rand(4);
        push_a_record(NAME_POINTER, $urandom());
        send_packet(12'(pkt.size()));

        // Zero answer count: records are not read.
        start_response(16'd0);
        push_question(1);
        push_a_record(NAME_POINTER, $urandom());
        send_packet(12'(pkt.size()));

        // Fewer than 12 bytes left at an answer start.
        start_response(16'd2);
        push_question(1);
        push_a_record(NAME_POINTER, $urandom());
        push_rand(11);
        send_packet(12'(pkt.size()));

        // Fixed part of an answer does not fit.
        start_response(16'd1);
        push_question(1);
        push_name(2);
        push_rand(9);
        send_packet(12'(pkt.size()));
        wait_drained();

        // Random packets under each idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            start     = sent_count;
            while (sent_count - start < PHASE_BYTES) begin
                if ($urandom_range(0, 19) == 0) wait_drained();
                send_random_packet();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
